@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of the block LMS filter.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked assertion with explicit clock and active-low reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion on the house clock and reset.
`define ASSERT_STD(lbl, prop, msg) \
  `ASSERT_AT(lbl, clk_i, rst_ni, prop, msg)

`else

`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_STD(lbl, prop, msg)

`endif

`endif

@@ rtl/core/blms_pkg.sv @@
// Package for the block LMS adaptive FIR: sizes, formats, register and state codes.
// No dependencies; used by the interfaces and the top level.
`default_nettype none

package blms_pkg;

  // Filter geometry. Block length is a power of two: the step-term
  // divide by BLOCK * 2^26 is then an arithmetic shift.
  localparam int TAPS       = 32;
  localparam int TAP_IDX_W  = $clog2(TAPS);
  localparam int TAP_CNT_W  = $clog2(TAPS + 1);
  localparam int BLOCK_LOG2 = 6;
  localparam int BLOCK      = 1 << BLOCK_LOG2;
  localparam int POS_W      = (BLOCK_LOG2 > 0) ? BLOCK_LOG2 : 1;

  // Field and state widths.
  localparam int SAMPLE_W = 16;
  localparam int WEIGHT_W = 24;   // Q4.20
  localparam int GRAD_W   = 48;   // Q?.30
  localparam int STEP_W   = 16;   // Q0.16
  localparam int LEAK_W   = 17;   // Q1.16

  // Shared multiplier: 25 x 18 signed.
  localparam int MUL_A_W = WEIGHT_W + 1;
  localparam int MUL_B_W = LEAK_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // FIR accumulator: exact sum of TAPS products of 24 x 16 bits.
  localparam int ACC_W    = WEIGHT_W + SAMPLE_W + TAP_CNT_W;
  localparam int Y_FRAC   = 20;
  localparam int YS_W     = ACC_W - Y_FRAC;

  // Weight update.
  localparam int LK_SHIFT = 16;
  localparam int LK_W     = PROD_W - LK_SHIFT;
  localparam int UPD_W    = 66;
  localparam int UPD_SH   = 26 + BLOCK_LOG2;
  localparam int STP_W    = UPD_W - UPD_SH;
  localparam int SUM_W    = STP_W + 1;
  localparam int GLO_W    = GRAD_W / 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = LEAK_W;

  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(328);
  localparam logic [LEAK_W-1:0] LEAK_RESET = LEAK_W'(65536);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [WEIGHT_W-1:0] weight_t;
  typedef logic signed [GRAD_W-1:0]   grad_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_SIZE = 8'd0,
    REG_LEAKAGE   = 8'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIR,
    ST_Y,
    ST_E,
    ST_GRAD,
    ST_UPD,
    ST_DONE
  } state_e;

  // Sub-steps of one tap during the weight update.
  typedef enum logic [2:0] {
    US_LEAK,
    US_LO,
    US_HI,
    US_SUM,
    US_WRITE
  } upd_step_e;

endpackage

`default_nettype wire

@@ rtl/core/blms_if.sv @@
// Valid/ready channel interfaces of the block LMS filter: samples in, results out, config.
// Depends on blms_pkg.
`default_nettype none

interface blms_in_if;
  import blms_pkg::*;
  logic    valid;
  logic    ready;
  sample_t ref_sample;
  sample_t desired_sample;

  modport source (output valid, output ref_sample, output desired_sample, input ready);
  modport sink   (input valid, input ref_sample, input desired_sample, output ready);
endinterface

interface blms_out_if;
  import blms_pkg::*;
  logic    valid;
  logic    ready;
  sample_t filter_out;
  sample_t error_out;
  logic    block_end;

  modport source (output valid, output filter_out, output error_out, output block_end,
                  input ready);
  modport sink   (input valid, input filter_out, input error_out, input block_end,
                  output ready);
endinterface

interface blms_cfg_if;
  import blms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/block_lms_adaptive_fir.sv @@
// Top level of the leaky block LMS adaptive FIR filter (time domain, fixed point).
// Depends on blms_pkg, the interfaces in blms_if.sv and assert_macros.svh.
//
//   channel  | dir | payload                                   | transfer
//   ---------+-----+-------------------------------------------+-------------------
//   in_i     | in  | ref_sample, desired_sample (Q1.15)        | valid & ready
//   out_o    | out | filter_out, error_out (Q1.15), block_end  | valid & ready
//   cfg_i    | in  | index (0 step_size, 1 leakage), data      | valid & ready
//
// One 25x18 multiplier does all the arithmetic. A sample goes from input
// transfer to the next ready through the filter sum over all taps, the
// rounding of y and e, and the gradient sums over all taps.
// The last sample of a block adds the weight update of every tap.
// Reset clears history, weights, gradients and block position at once.
// A result waits in the output register; the next sample is taken meanwhile
// and stalls only in its last cycle if that result is still not taken.
// cfg_i is always ready; writes to unknown indexes are dropped.
`default_nettype none
`include "assert_macros.svh"

module block_lms_adaptive_fir (
  input  logic       clk_i,
  input  logic       rst_ni,
  blms_in_if.sink    in_i,
  blms_out_if.source out_o,
  blms_cfg_if.sink   cfg_i
);
  import blms_pkg::*;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_e                      state_q, state_d;
  upd_step_e                   sub_q;
  logic [TAP_CNT_W-1:0]        k_q;
  logic [TAP_IDX_W-1:0]        kp_q;     // registered tap index: the value of k_q in the previous cycle
  logic [POS_W-1:0]            pos_q;
  logic [STEP_W-1:0]           step_q;
  logic [LEAK_W-1:0]           leak_q;

  sample_t                     hist_q   [TAPS];  // index 0 newest
  weight_t                     weight_q [TAPS];
  grad_t                       grad_q   [TAPS];

  sample_t                     d_q;
  sample_t                     y_q;
  sample_t                     e_q;
  logic                        be_q;
  logic signed [PROD_W-1:0]    prod_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [LK_W-1:0]      lk_q;
  logic signed [UPD_W-1:0]     upd_q;

  logic                        out_valid_q;
  sample_t                     out_y_q;
  sample_t                     out_e_q;
  logic                        out_be_q;

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  logic in_fire;
  logic out_load;
  logic cfg_fire;
  logic k_last;
  logic last_of_block;

  assign in_fire       = in_i.valid && in_i.ready;
  assign cfg_fire      = cfg_i.valid && cfg_i.ready;
  assign k_last        = (k_q == TAP_CNT_W'(TAPS));
  assign last_of_block = (pos_q == POS_W'(BLOCK - 1));

  assign cfg_i.ready     = 1'b1;
  assign out_o.valid     = out_valid_q;
  assign out_o.filter_out = out_y_q;
  assign out_o.error_out  = out_e_q;
  assign out_o.block_end  = out_be_q;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_FIR;
      end
      ST_FIR: begin
        if (k_last) state_d = ST_Y;
      end
      ST_Y:    state_d = ST_E;
      ST_E:    state_d = ST_GRAD;
      ST_GRAD: begin
        if (k_last) state_d = last_of_block ? ST_UPD : ST_DONE;
      end
      ST_UPD: begin
        if ((k_q == TAP_CNT_W'(TAPS - 1)) && (sub_q == US_WRITE)) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    in_i.ready = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: in_i.ready = 1'b1;
      ST_DONE: out_load   = !out_valid_q || out_o.ready;
      default: begin
        in_i.ready = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Array read ports (one address each)
  // ---------------------------------------------------------------------------
  logic [TAP_IDX_W-1:0] k_idx;
  logic [TAP_IDX_W-1:0] g_addr;
  sample_t              x_rd;
  weight_t              w_rd;
  grad_t                g_rd;

  assign k_idx  = k_q[TAP_IDX_W-1:0];
  assign g_addr = (state_q == ST_GRAD) ? kp_q : k_idx;
  assign x_rd   = hist_q[k_idx];
  assign w_rd   = weight_q[k_idx];
  assign g_rd   = grad_q[g_addr];

  // ---------------------------------------------------------------------------
  // Shared multiplier operand select
  // ---------------------------------------------------------------------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_FIR: begin
        mul_a = MUL_A_W'(w_rd);
        mul_b = MUL_B_W'(x_rd);
      end
      ST_GRAD: begin
        mul_a = MUL_A_W'(e_q);
        mul_b = MUL_B_W'(x_rd);
      end
      ST_UPD: begin
        case (sub_q)
          US_LEAK: begin
            mul_a = MUL_A_W'(w_rd);
            mul_b = {1'b0, leak_q};
          end
          US_LO: begin
            // low half of the gradient, taken as unsigned
            mul_a = {1'b0, g_rd[GLO_W-1:0]};
            mul_b = {{(MUL_B_W - STEP_W){1'b0}}, step_q};
          end
          US_HI: begin
            mul_a = MUL_A_W'($signed(g_rd[GRAD_W-1:GLO_W]));
            mul_b = {{(MUL_B_W - STEP_W){1'b0}}, step_q};
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Rounding and saturation
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0]    y_round;
  logic signed [YS_W-1:0]     y_shift;
  sample_t                    y_sat;
  logic signed [SAMPLE_W:0]   e_diff;
  sample_t                    e_sat;
  logic signed [GRAD_W:0]     g_sum;
  grad_t                      g_sat;
  logic signed [PROD_W-1:0]   lk_round;
  logic signed [STP_W-1:0]    stp;
  logic signed [SUM_W-1:0]    w_sum;
  weight_t                    w_sat;

  always_comb begin
    // y: round half up at bit 20, then clamp to 16 bits
    y_round = acc_q + ACC_W'(2 ** (Y_FRAC - 1));
    y_shift = y_round[ACC_W-1:Y_FRAC];
    if ((&y_shift[YS_W-1:SAMPLE_W-1]) || !(|y_shift[YS_W-1:SAMPLE_W-1])) begin
      y_sat = y_shift[SAMPLE_W-1:0];
    end else begin
      y_sat = {y_shift[YS_W-1], {(SAMPLE_W - 1){~y_shift[YS_W-1]}}};
    end

    e_diff = (SAMPLE_W + 1)'(d_q) - (SAMPLE_W + 1)'(y_q);
    if (e_diff[SAMPLE_W] == e_diff[SAMPLE_W-1]) begin
      e_sat = e_diff[SAMPLE_W-1:0];
    end else begin
      e_sat = {e_diff[SAMPLE_W], {(SAMPLE_W - 1){~e_diff[SAMPLE_W]}}};
    end

    // gradient add, clamp to 48 bits
    g_sum = (GRAD_W + 1)'(g_rd) + (GRAD_W + 1)'(prod_q);
    if (g_sum[GRAD_W] == g_sum[GRAD_W-1]) begin
      g_sat = g_sum[GRAD_W-1:0];
    end else begin
      g_sat = {g_sum[GRAD_W], {(GRAD_W - 1){~g_sum[GRAD_W]}}};
    end

    // leak term: (leakage*w + 2^15) >> 16, floor
    lk_round = prod_q + PROD_W'(2 ** (LK_SHIFT - 1));

    // step term: floor divide by BLOCK*2^26 is an arithmetic shift
    stp   = upd_q[UPD_W-1:UPD_SH];
    w_sum = SUM_W'(lk_q) + SUM_W'(stp);
    if ((&w_sum[SUM_W-1:WEIGHT_W-1]) || !(|w_sum[SUM_W-1:WEIGHT_W-1])) begin
      w_sat = w_sum[WEIGHT_W-1:0];
    end else begin
      w_sat = {w_sum[SUM_W-1], {(WEIGHT_W - 1){~w_sum[SUM_W-1]}}};
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sub_q       <= US_LEAK;
      k_q         <= '0;
      kp_q        <= '0;
      pos_q       <= '0;
      be_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      kp_q    <= k_idx;

      // tap counter restarts on every phase change
      if (state_d != state_q) begin
        k_q <= '0;
      end else if ((state_q == ST_FIR) || (state_q == ST_GRAD)) begin
        k_q <= k_q + 1'b1;
      end else if ((state_q == ST_UPD) && (sub_q == US_WRITE)) begin
        k_q <= k_q + 1'b1;
      end

      if (state_q == ST_UPD) begin
        sub_q <= (sub_q == US_WRITE) ? US_LEAK : upd_step_e'(sub_q + 1'b1);
      end else begin
        sub_q <= US_LEAK;
      end

      if (in_fire) be_q <= 1'b0;
      if ((state_q == ST_GRAD) && k_last) begin
        be_q  <= last_of_block;
        pos_q <= last_of_block ? '0 : pos_q + 1'b1;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
      leak_q <= LEAK_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_STEP_SIZE: step_q <= cfg_i.data[STEP_W-1:0];
        REG_LEAKAGE:   leak_q <= cfg_i.data[LEAK_W-1:0];
        default: begin
          step_q <= step_q;
          leak_q <= leak_q;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Filter state: history, weights, gradient sums
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_q[i]   <= '0;
        weight_q[i] <= '0;
        grad_q[i]   <= '0;
      end
    end else begin
      if (in_fire) begin
        hist_q[0] <= in_i.ref_sample;
        for (int i = 1; i < TAPS; i++) begin
          hist_q[i] <= hist_q[i-1];
        end
      end
      // the registered product belongs to the previous tap, kp_q
      if ((state_q == ST_GRAD) && (k_q != '0)) begin
        grad_q[kp_q] <= g_sat;
      end
      if ((state_q == ST_UPD) && (sub_q == US_WRITE)) begin
        weight_q[k_idx] <= w_sat;
        grad_q[k_idx]   <= '0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;

    if (in_fire) begin
      d_q   <= in_i.desired_sample;
      acc_q <= '0;
    end else if ((state_q == ST_FIR) && (k_q != '0)) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end

    if (state_q == ST_Y) y_q <= y_sat;
    if (state_q == ST_E) e_q <= e_sat;

    if (state_q == ST_UPD) begin
      case (sub_q)
        US_LO:  lk_q  <= lk_round[PROD_W-1:LK_SHIFT];
        US_HI:  upd_q <= UPD_W'(prod_q) + (UPD_W'(1) <<< (UPD_SH - 1));
        US_SUM: upd_q <= upd_q + (UPD_W'(prod_q) <<< GLO_W);
        default: begin
          lk_q  <= lk_q;
          upd_q <= upd_q;
        end
      endcase
    end

    if (out_load) begin
      out_y_q  <= y_q;
      out_e_q  <= e_q;
      out_be_q <= be_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ASSERT_STD(a_accept_starts_fir, in_fire |=> (state_q == ST_FIR), "accept did not start FIR")
  `ASSERT_STD(a_upd_pos_cleared, (state_q == ST_UPD) |-> (pos_q == '0), "block position not reset")
  `ASSERT_STD(a_done_holds, (state_q == ST_DONE && out_valid_q && !out_o.ready) |=> (state_q == ST_DONE), "result overwritten")
  `ASSERT_STD(a_tap_range, k_q <= TAP_CNT_W'(TAPS), "tap counter out of range")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for block_lms_adaptive_fir: directed table, then randomized phases.
// Depends on blms_pkg and the channel interfaces in blms_if.sv; the RTL is the only other input.
`timescale 1ns / 100ps

module tb;
  import blms_pkg::*;

  // Run control. The longest quiet stretch in a correct run is the long
  // sink hold-off below; the watchdog limit sits well above it.
  localparam int WATCHDOG_LIMIT = 4000;
  // The settle time covers one sample plus the weight update at block end.
  localparam int CFG_SETTLE     = 256;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLD_AT        = 230;   // result count that triggers the long hold-off
  localparam int HOLD_LEN       = 800;
  localparam int N_DIRECTED     = 20;
  localparam int N_PHASES       = 8;

  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TOP   = '1;

  localparam longint UPD_DEN = longint'(BLOCK) <<< 26;
  localparam logic [3:0][SAMPLE_W-1:0] CORNER_SAMPLES = {16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

  typedef struct {
    sample_t filt;
    sample_t err;
    logic    closed;
  } fir_result_t;

  typedef struct {
    sample_t     x;
    sample_t     d;
    fir_result_t want;
  } directed_row_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] step_data;
    logic [CFG_DATA_W-1:0] leak_data;
    bit                    pick_random;
    int                    n_items;
    bit                    idling;
  } phase_t;

  logic clk;
  logic rst_n;

  blms_in_if  in_ch ();
  blms_out_if out_ch ();
  blms_cfg_if cfg_ch ();

  block_lms_adaptive_fir DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of history, weights, gradients and config.
  // ---------------------------------------------------------------------------
  sample_t              x_hist   [TAPS];
  weight_t              wts      [TAPS];
  grad_t                grad_acc [TAPS];
  int                   blk_pos;
  logic [STEP_W-1:0]    step_reg;
  logic [LEAK_W-1:0]    leak_reg;

  fir_result_t pending_results [$];
  fir_result_t no_typed;
  sample_t     plant_hist [4];

  int  mismatches;
  int  results_seen;
  int  quiet_cycles;
  bit  src_idling;
  bit  snk_idling;

  // After reset the weights are zero, so y is 0 and e is d for the whole first block.
  directed_row_t dir_rows [N_DIRECTED] = '{
    '{16'sh8000, 16'sh7FFF, '{16'sh0000, 16'sh7FFF, 1'b0}},   // full-scale opposite
    '{16'sh7FFF, 16'sh8000, '{16'sh0000, 16'sh8000, 1'b0}},
    '{16'sh0000, 16'sh0000, '{16'sh0000, 16'sh0000, 1'b0}},
    '{16'shFFFF, 16'shFFFF, '{16'sh0000, 16'shFFFF, 1'b0}},
    '{16'sh7FFF, 16'sh7FFF, '{16'sh0000, 16'sh7FFF, 1'b0}},
    '{16'sh8000, 16'sh8000, '{16'sh0000, 16'sh8000, 1'b0}},
    '{16'sh0001, 16'shFFFF, '{16'sh0000, 16'shFFFF, 1'b0}},
    '{16'sh5555, 16'shAAAA, '{16'sh0000, 16'shAAAA, 1'b0}},   // alternating bits
    '{16'shAAAA, 16'sh5555, '{16'sh0000, 16'sh5555, 1'b0}},
    '{16'sh4000, 16'shC000, '{16'sh0000, 16'shC000, 1'b0}},
    '{16'shC000, 16'sh4000, '{16'sh0000, 16'sh4000, 1'b0}},
    '{16'sh00FF, 16'shFF00, '{16'sh0000, 16'shFF00, 1'b0}},
    '{16'shFF00, 16'sh00FF, '{16'sh0000, 16'sh00FF, 1'b0}},
    '{16'sh0F0F, 16'shF0F0, '{16'sh0000, 16'shF0F0, 1'b0}},
    '{16'shF0F0, 16'sh0F0F, '{16'sh0000, 16'sh0F0F, 1'b0}},
    '{16'sh3333, 16'shCCCC, '{16'sh0000, 16'shCCCC, 1'b0}},
    '{16'sh8001, 16'sh7FFE, '{16'sh0000, 16'sh7FFE, 1'b0}},
    '{16'sh0001, 16'sh0001, '{16'sh0000, 16'sh0001, 1'b0}},
    '{16'sh7FFF, 16'sh0000, '{16'sh0000, 16'sh0000, 1'b0}},
    '{16'sh8000, 16'sh0000, '{16'sh0000, 16'sh0000, 1'b0}}
  };

  // Config per phase. Phase 0 runs on the reset values and writes nothing.
  phase_t phases [N_PHASES] = '{
    '{17'd328,    17'd65536,  1'b0, 100, 1'b1},
    '{17'd65535,  17'd65536,  1'b0, 100, 1'b1},   // fastest adaptation
    '{17'd65535,  17'd131071, 1'b0, 110, 1'b1},   // gain above one, weights saturate
    '{17'd0,      17'd0,      1'b0, 100, 1'b0},   // full leak wipes weights, no gaps
    '{17'h1FFFF,  17'd65536,  1'b0, 100, 1'b1},   // bit 16 of step must be dropped
    '{17'd20000,  17'd60000,  1'b0, 100, 1'b1},
    '{17'd0,      17'd0,      1'b1, 100, 1'b1},   // random step and leak
    '{17'd328,    17'd65536,  1'b0, 100, 1'b0}    // tail of the run, no gaps
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint saturate(input longint v, input int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Floor division, matching the rounding of the step term.
  function automatic longint floor_div(input longint n, input longint den);
    if (n >= 0) return n / den;
    return -1 - ((-1 - n) / den);
  endfunction

  // One sample through the filter: y from the held weights, e = d - y,
  // gradient accumulation, and the leaky weight update at block end.
  function automatic fir_result_t predict_sample(input sample_t x, input sample_t d);
    fir_result_t r;
    longint      acc;
    longint      y;
    longint      e;
    longint      leak_term;
    longint      step_term;
    acc = 0;
    for (int k = TAPS - 1; k > 0; k--) x_hist[k] = x_hist[k-1];
    x_hist[0] = x;
    for (int k = 0; k < TAPS; k++) acc += longint'(wts[k]) * longint'(x_hist[k]);
    y = saturate((acc + (longint'(1) <<< (Y_FRAC - 1))) >>> Y_FRAC, SAMPLE_W);
    e = saturate(longint'(d) - y, SAMPLE_W);
    for (int k = 0; k < TAPS; k++)
      grad_acc[k] = grad_t'(saturate(longint'(grad_acc[k]) + e * longint'(x_hist[k]), GRAD_W));
    blk_pos++;
    r.closed = 1'b0;
    if (blk_pos >= BLOCK) begin
      for (int k = 0; k < TAPS; k++) begin
        leak_term = (longint'(leak_reg) * longint'(wts[k]) + 32768) >>> 16;
        step_term = floor_div(longint'(step_reg) * longint'(grad_acc[k]) + UPD_DEN / 2,
                              UPD_DEN);
        wts[k]      = weight_t'(saturate(leak_term + step_term, WEIGHT_W));
        grad_acc[k] = '0;
      end
      blk_pos  = 0;
      r.closed = 1'b1;
    end
    r.filt = sample_t'(y);
    r.err  = sample_t'(e);
    return r;
  endfunction

  // Random sample pair. Most are a noisy unknown plant (x, x[n-2] and x[n-4])
  // driven by x at a random level, so the weights actually converge; the rest
  // are raw noise and full-scale corners.
  function automatic void make_random_sample(output sample_t x, output sample_t d);
    int unsigned pick;
    int          lvl;
    int          noise;
    longint      plant;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      lvl   = $urandom_range(0, 4);
      x     = sample_t'($urandom) >>> lvl;
      noise = int'($urandom_range(0, 63)) - 32;
      plant = (longint'(x) >>> 1) + (longint'(plant_hist[1]) >>> 2)
              - (longint'(plant_hist[3]) >>> 3) + noise;
      d     = sample_t'(saturate(plant, SAMPLE_W));
    end else if (pick < 8) begin
      x = sample_t'($urandom);
      d = sample_t'($urandom);
    end else begin
      x = sample_t'(CORNER_SAMPLES[$urandom_range(0, 3)]);
      d = sample_t'(CORNER_SAMPLES[$urandom_range(0, 3)]);
    end
    for (int k = 3; k > 0; k--) plant_hist[k] = plant_hist[k-1];
    plant_hist[0] = x;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 200) $display("%0t: result %0d: %s", $time, results_seen, what);
  endtask

  // Called right after a falling edge; returns right after the next one
  // following the transfer, with valid still high.
  task automatic send_sample(input sample_t x, input sample_t d, input bit typed,
                             input fir_result_t typed_res);
    fir_result_t r;
    in_ch.valid          = 1'b1;
    in_ch.ref_sample     = x;
    in_ch.desired_sample = d;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = predict_sample(x, d);
    pending_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_STEP_SIZE: step_reg = value[STEP_W-1:0];
      REG_LEAKAGE:   leak_reg = value;
      default: ;   // unknown index: dropped
    endcase
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, then phases of random samples with a
  // config change in between. Config only moves once all results are drained and the filter is idle.
  // ---------------------------------------------------------------------------
  initial begin
    sample_t               x;
    sample_t               d;
    logic [CFG_DATA_W-1:0] step_val;
    logic [CFG_DATA_W-1:0] leak_val;

    in_ch.valid          = 1'b0;
    in_ch.ref_sample     = '0;
    in_ch.desired_sample = '0;
    out_ch.ready         = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = '0;
    cfg_ch.data          = '0;
    no_typed             = '{16'sh0000, 16'sh0000, 1'b0};
    for (int k = 0; k < TAPS; k++) begin
      x_hist[k]   = '0;
      wts[k]      = '0;
      grad_acc[k] = '0;
    end
    for (int k = 0; k < 4; k++) plant_hist[k] = '0;
    blk_pos      = 0;
    step_reg     = STEP_RESET;
    leak_reg     = LEAK_RESET;
    mismatches   = 0;
    results_seen = 0;
    src_idling   = 1'b1;
    snk_idling   = 1'b1;

    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++)
      send_sample(dir_rows[i].x, dir_rows[i].d, 1'b1, dir_rows[i].want);

    for (int p = 0; p < N_PHASES; p++) begin
      if (p != 0) begin
        // Drain all pending results, then wait out the settle time.
        in_ch.valid = 1'b0;
        while (pending_results.size() != 0) @(negedge clk);
        repeat (CFG_SETTLE) @(negedge clk);
        step_val = phases[p].step_data;
        leak_val = phases[p].leak_data;
        if (phases[p].pick_random) begin
          step_val = CFG_DATA_W'($urandom_range(0, 65535));
          leak_val = CFG_DATA_W'($urandom_range(0, 131071));
        end
        cfg_write(REG_STEP_SIZE, step_val);
        cfg_write(REG_LEAKAGE, leak_val);
        cfg_write((p % 2) ? REG_SPARE : REG_TOP, CFG_DATA_W'($urandom));
        cfg_ch.valid = 1'b0;
      end
      src_idling = phases[p].idling;
      snk_idling = phases[p].idling;
      for (int n = 0; n < phases[p].n_items; n++) begin
        if (src_idling && $urandom_range(0, 3) == 0) begin
          in_ch.valid = 1'b0;
          repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        make_random_sample(x, d);
        send_sample(x, d, 1'b0, no_typed);
      end
    end
    in_ch.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("block_lms_adaptive_fir test passed");
    end else begin
      $display("block_lms_adaptive_fir test failed");
    end
    $finish;
  end

  // Result sink: random bursts of backpressure, plus one long hold-off so the
  // result register fills and the next sample stalls on the input side.
  initial begin
    int gap;
    int hold;
    bit held;
    gap  = 0;
    hold = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ch.ready = 1'b0;
      end else if (!held && results_seen >= HOLD_AT) begin
        held         = 1'b1;
        hold         = HOLD_LEN - 1;
        out_ch.ready = 1'b0;
      end else if (gap > 0) begin
        gap--;
        out_ch.ready = 1'b0;
      end else if (snk_idling && $urandom_range(0, 4) == 0) begin
        gap          = $urandom_range(1, 11) - 1;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Result check: every transfer against the oldest expectation.
  always @(posedge clk) begin
    fir_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result y=%0d e=%0d end=%0b",
                                  out_ch.filter_out, out_ch.error_out, out_ch.block_end));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.filter_out !== want.filt)
          report_mismatch($sformatf("filter_out %0d, expected %0d", out_ch.filter_out, want.filt));
        if (out_ch.error_out !== want.err)
          report_mismatch($sformatf("error_out %0d, expected %0d", out_ch.error_out, want.err));
        if (out_ch.block_end !== want.closed)
          report_mismatch($sformatf("block_end %0b, expected %0b", out_ch.block_end,
                                    want.closed));
      end
    end
  end

  // Watchdog: cycles without a transfer on any channel.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("block_lms_adaptive_fir test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial quiet_cycles = 0;

endmodule
